### src/battery_level_estimator_assert.svh
// Assertion macros for the battery level estimator.
`ifndef BATTERY_LEVEL_ESTIMATOR_ASSERT_SVH
`define BATTERY_LEVEL_ESTIMATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// Shared constants, types and the Li-ion voltage table.
// ----------------------------------------------------------------------------
package ble_pkg;
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_REAL = 2'd1;
    localparam logic [1:0] MODE_SIM  = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_SIMLVL = 3'd1;
    localparam logic [2:0] REG_BLEND  = 3'd2;
    localparam logic [2:0] REG_WEIGHT = 3'd3;
    localparam logic [2:0] REG_CAL    = 3'd4;
    localparam logic [2:0] REG_SMOOTH = 3'd5;

    localparam logic [3:0] FLAG_CHG = 4'h1;
    localparam logic [3:0] FLAG_DIS = 4'h2;
    localparam logic [3:0] FLAG_AC  = 4'h4;

    localparam logic [15:0] MV_LO_USE  = 16'd2500;
    localparam logic [15:0] MV_HI      = 16'd4500;
    localparam logic [15:0] MV_LO_CAL  = 16'd3000;

    // divider request / reply
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

    function automatic logic [15:0] liion_mv(input logic [3:0] i);
        case (i)
            4'd0: liion_mv = 16'd3000;
            4'd1: liion_mv = 16'd3300;
            4'd2: liion_mv = 16'd3400;
            4'd3: liion_mv = 16'd3500;
            4'd4: liion_mv = 16'd3600;
            4'd5: liion_mv = 16'd3700;
            4'd6: liion_mv = 16'd3800;
            4'd7: liion_mv = 16'd3900;
            4'd8: liion_mv = 16'd4000;
            4'd9: liion_mv = 16'd4100;
            default: liion_mv = 16'd4200;
        endcase
    endfunction

    function automatic logic [6:0] liion_pct(input logic [3:0] i);
        case (i)
            4'd0: liion_pct = 7'd0;
            4'd1: liion_pct = 7'd3;
            4'd2: liion_pct = 7'd6;
            4'd3: liion_pct = 7'd10;
            4'd4: liion_pct = 7'd18;
            4'd5: liion_pct = 7'd32;
            4'd6: liion_pct = 7'd48;
            4'd7: liion_pct = 7'd65;
            4'd8: liion_pct = 7'd82;
            4'd9: liion_pct = 7'd93;
            default: liion_pct = 7'd100;
        endcase
    endfunction
endpackage

### src/ble_div.sv
// ----------------------------------------------------------------------------
// ble_div
// Restoring divider, one quotient bit per cycle, 32 by 16 bits.
// ----------------------------------------------------------------------------
module ble_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ble_pkg::t_div_req i_req,
    output ble_pkg::t_div_rsp o_rsp
);
    import ble_pkg::*;

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den, n_den;
    logic        r_done, n_done;
    logic [16:0] w_sh;

    assign w_sh = {r_rem[15:0], r_quo[31]};

    // one shift-subtract step per cycle
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd32;
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

### src/battery_level_estimator.sv
// Simulated mode and the blend-off path go straight to the final steps; with the blend on,
// the voltage is interpolated on the Li-ion table or, with calibration, on the gathered and
// sorted anchors, and the divider may be used.
// One transaction at a time; the next is accepted in the cycle after the result leaves.
// Synchronous active-low reset clears the configuration, the persistent state and the
// sequencer; the working registers are not reset.
// ----------------------------------------------------------------------------
// battery_level_estimator
// Per-tick battery percent, runtime and flags from status byte and voltage.
// ----------------------------------------------------------------------------
`include "battery_level_estimator_assert.svh"
module battery_level_estimator #(
    parameter int ANCHOR_COUNT = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] status_byte, [23:8] supply_mv
    input  logic [23:0] s_axis_tdata,
    // [0] voltage_fresh
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] remaining_pct, [19:7] runtime_min, [23:20] status_flags
    output logic [23:0] m_axis_tdata,
    // [0] anchors_changed
    output logic        m_axis_tuser
);
    import ble_pkg::*;

    localparam int AW = $clog2(ANCHOR_COUNT);
    // counter also walks the 11-point Li-ion table, so never narrower than 4 bits
    localparam int CW = ($clog2(ANCHOR_COUNT + 1) < 4) ? 4 : $clog2(ANCHOR_COUNT + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ANC    = 4'd1;
    localparam logic [3:0] S_COL    = 4'd2;
    localparam logic [3:0] S_SORT   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_TAB    = 4'd5;
    localparam logic [3:0] S_DIVW   = 4'd6;
    localparam logic [3:0] S_BLEND  = 4'd7;
    localparam logic [3:0] S_BDIV   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_DEMO   = 4'd11;

    // configuration
    logic [1:0] r_mode;
    logic [7:0] r_simlvl, r_weight;
    logic       r_blend, r_cal, r_smooth;

    // persistent state
    logic [15:0] r_anc [ANCHOR_COUNT];
    logic [15:0] r_vcache;
    logic [6:0]  r_slvl;
    logic        r_seeded;
    logic [9:0]  r_demo;

    // working registers
    logic [3:0]  r_st;
    logic [7:0]  r_b;
    logic [3:0]  r_lvl10;
    logic [15:0] r_v;
    logic [15:0] r_pm [ANCHOR_COUNT];
    logic [3:0]  r_pp [ANCHOR_COUNT];
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i, r_j;
    logic [6:0]  r_base;
    logic        r_neg;
    logic [6:0]  r_vp;
    logic [6:0]  r_lvl;
    logic [15:0] r_bnum;
    logic        r_chg;
    logic        r_changed;
    logic [23:0] r_odata;
    logic        r_ouser, r_ovalid;

    t_div_req r_div_req;
    t_div_rsp w_rsp;

    ble_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_div_req), .o_rsp(w_rsp));

    logic        w_acc;
    logic [7:0]  w_b;
    logic [3:0]  w_st, w_l10;
    logic [15:0] w_mv;
    logic        w_fresh;
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_b     = s_axis_tdata[7:0];
    assign w_mv    = s_axis_tdata[23:8];
    assign w_fresh = s_axis_tuser;
    assign w_st    = w_b[7:4];
    assign w_l10   = (w_b[3:0] > 4'd10) ? 4'd10 : w_b[3:0];

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // EMA step on the selected anchor
    logic [15:0] w_aold;
    logic signed [17:0] w_d, w_step;
    logic [15:0] w_anew;
    assign w_aold = r_anc[r_lvl10[AW-1:0]];
    assign w_d    = $signed({2'b00, r_v}) - $signed({2'b00, w_aold});
    assign w_step = w_d[17] ? -((-w_d + 18'sd4) >>> 3) : ((w_d + 18'sd4) >>> 3);
    assign w_anew = (w_aold == 16'd0) ? r_v : (w_aold + w_step[15:0]);

    // sort compare (insertion sort, adjacent swap)
    logic [CW-1:0] w_jm1;
    assign w_jm1 = r_j - CW'(1);

    // blend multiply-add
    logic [6:0]  w_lp;
    logic [15:0] w_bnum;
    assign w_lp   = 7'(r_lvl10 * 4'd10);
    assign w_bnum = 16'(r_vp * r_weight) + 16'(w_lp * (8'd100 - r_weight)) + 16'd50;

    // divide by 100 as reciprocal multiply, exact up to the largest blend sum
    logic [28:0] w_bq;
    assign w_bq = 29'(r_bnum * 13'd5243);

    // demo ramp step, divide by 10 as reciprocal multiply
    logic [9:0]  w_dm5;
    logic [17:0] w_dq;
    assign w_dm5 = r_demo - 10'd5;
    assign w_dq  = 18'(w_dm5 * 8'd205);

    // clamp and smoothing
    logic [6:0] w_tgt;
    logic signed [8:0] w_sd, w_ss, w_nx;
    assign w_tgt = (r_lvl > 7'd100) ? 7'd100 : ((r_lvl < 7'd5) ? 7'd5 : r_lvl);
    assign w_sd  = $signed({2'b00, w_tgt}) - $signed({2'b00, r_slvl});
    always_comb begin
        w_ss = w_sd[8] ? -((-w_sd + 9'sd3) >>> 2) : ((w_sd + 9'sd3) >>> 2);
        if (w_ss == 9'sd0) w_ss = w_sd[8] ? -9'sd1 : 9'sd1;
        w_nx = $signed({2'b00, r_slvl}) + w_ss;
    end

    logic [6:0] w_sim;
    assign w_sim = (r_simlvl > 8'd100) ? 7'd100 :
                   ((r_simlvl < 8'd5) ? 7'd5 : r_simlvl[6:0]);

    logic [CW-1:0] w_im1;
    assign w_im1 = r_i - CW'(1);

    always_ff @(posedge i_clk) begin
        r_div_req.start <= 1'b0;
        if (!i_rst_n) begin
            r_mode <= MODE_REAL; r_simlvl <= 8'd100; r_blend <= 1'b0;
            r_weight <= 8'd50; r_cal <= 1'b0; r_smooth <= 1'b0;
            for (int k = 0; k < ANCHOR_COUNT; k++) r_anc[k] <= '0;
            r_vcache <= '0; r_slvl <= 7'd100; r_seeded <= 1'b0; r_demo <= 10'd1000;
            r_st <= S_IDLE; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MODE:   r_mode   <= i_cfg_data[1:0];
                    REG_SIMLVL: r_simlvl <= i_cfg_data;
                    REG_BLEND:  r_blend  <= i_cfg_data[0];
                    REG_WEIGHT: r_weight <= i_cfg_data;
                    REG_CAL:    r_cal    <= i_cfg_data[0];
                    REG_SMOOTH: r_smooth <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (w_acc) begin
                    r_b <= w_b; r_lvl10 <= w_l10; r_v <= w_mv;
                    r_changed <= 1'b0;
                    r_chg <= (w_st == 4'd1) || (w_st == 4'd2);
                    if (r_mode == MODE_SIM) begin
                        r_lvl <= w_sim;
                        r_st <= S_DEMO;
                    end else if (r_mode != MODE_OFF && w_b != 8'd0) begin
                        if (!r_blend) begin
                            r_vcache <= '0;
                            r_lvl <= 7'(w_l10 * 4'd10);
                            r_st <= S_FIN;
                        end else begin
                            r_i <= '0; r_n <= '0;
                            if (w_fresh) r_vcache <= w_mv;
                            if (w_fresh && r_cal && w_mv >= MV_LO_CAL && w_mv <= MV_HI
                                && 32'(w_l10) < ANCHOR_COUNT)
                                r_st <= S_ANC;
                            else
                                r_st <= S_COL;
                        end
                    end
                end
                S_ANC: begin
                    r_anc[r_lvl10[AW-1:0]] <= w_anew;
                    r_changed <= 1'b1;
                    r_v <= r_vcache;
                    r_st <= S_COL;
                    r_i <= '0; r_n <= '0;
                end
                S_COL: begin
                    // gather valid anchors one per cycle
                    r_v <= r_vcache;
                    if (r_vcache == 16'd0) begin
                        r_lvl <= 7'(r_lvl10 * 4'd10);
                        r_st <= S_FIN;
                    end else if (!r_cal) begin
                        r_i <= CW'(1);
                        r_st <= S_TAB;
                    end else if (r_i == CW'(ANCHOR_COUNT)) begin
                        if (r_n >= CW'(2)) begin
                            r_i <= CW'(1); r_j <= CW'(1); r_st <= S_SORT;
                        end else begin
                            r_i <= CW'(1); r_st <= S_TAB;
                        end
                    end else begin
                        if (r_anc[r_i[AW-1:0]] >= MV_LO_USE && r_anc[r_i[AW-1:0]] <= MV_HI)
                        begin
                            r_pm[r_n[AW-1:0]] <= r_anc[r_i[AW-1:0]];
                            r_pp[r_n[AW-1:0]] <= r_i[3:0];
                            r_n <= r_n + CW'(1);
                        end
                        r_i <= r_i + CW'(1);
                    end
                end
                S_SORT: begin
                    if (r_i >= r_n) begin
                        r_i <= CW'(1); r_st <= S_SCAN;
                    end else if (r_j != '0 && r_pm[w_jm1[AW-1:0]] > r_pm[r_j[AW-1:0]]) begin
                        r_pm[w_jm1[AW-1:0]] <= r_pm[r_j[AW-1:0]];
                        r_pm[r_j[AW-1:0]]   <= r_pm[w_jm1[AW-1:0]];
                        r_pp[w_jm1[AW-1:0]] <= r_pp[r_j[AW-1:0]];
                        r_pp[r_j[AW-1:0]]   <= r_pp[w_jm1[AW-1:0]];
                        r_j <= w_jm1;
                    end else begin
                        r_i <= r_i + CW'(1);
                        r_j <= r_i + CW'(1);
                    end
                end
                S_SCAN: begin
                    if (r_v <= r_pm[0]) begin
                        r_vp <= 7'(r_pp[0] * 4'd10); r_st <= S_BLEND;
                    end else if (r_v >= r_pm[w_im1[AW-1:0] + AW'(r_n - r_i)]) begin
                        r_vp <= 7'(r_pp[AW'(r_n - CW'(1))] * 4'd10); r_st <= S_BLEND;
                    end else if (r_v <= r_pm[r_i[AW-1:0]]) begin
                        r_base <= 7'(r_pp[w_im1[AW-1:0]] * 4'd10);
                        if (r_pm[r_i[AW-1:0]] == r_pm[w_im1[AW-1:0]]) begin
                            r_vp <= 7'(r_pp[w_im1[AW-1:0]] * 4'd10); r_st <= S_BLEND;
                        end else begin
                            r_neg <= r_pp[r_i[AW-1:0]] < r_pp[w_im1[AW-1:0]];
                            r_div_req.start <= 1'b1;
                            r_div_req.num <= 32'(r_v - r_pm[w_im1[AW-1:0]]) *
                                ((r_pp[r_i[AW-1:0]] < r_pp[w_im1[AW-1:0]]) ?
                                 32'(7'(r_pp[w_im1[AW-1:0]] * 4'd10)
                                     - 7'(r_pp[r_i[AW-1:0]] * 4'd10)) :
                                 32'(7'(r_pp[r_i[AW-1:0]] * 4'd10)
                                     - 7'(r_pp[w_im1[AW-1:0]] * 4'd10)));
                            r_div_req.den <= r_pm[r_i[AW-1:0]] - r_pm[w_im1[AW-1:0]];
                            r_st <= S_DIVW;
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_TAB: begin
                    if (r_v <= liion_mv(4'd0)) begin
                        r_vp <= liion_pct(4'd0); r_st <= S_BLEND;
                    end else if (r_v >= liion_mv(4'd10)) begin
                        r_vp <= liion_pct(4'd10); r_st <= S_BLEND;
                    end else if (r_v <= liion_mv(r_i[3:0])) begin
                        r_neg <= 1'b0;
                        r_base <= liion_pct(r_i[3:0] - 4'd1);
                        r_div_req.start <= 1'b1;
                        r_div_req.num <= 32'(r_v - liion_mv(r_i[3:0] - 4'd1)) *
                            32'(liion_pct(r_i[3:0]) - liion_pct(r_i[3:0] - 4'd1));
                        r_div_req.den <= liion_mv(r_i[3:0]) - liion_mv(r_i[3:0] - 4'd1);
                        r_st <= S_DIVW;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_DIVW: if (w_rsp.done) begin
                    r_vp <= r_neg ? 7'(r_base - w_rsp.quo[6:0]) : 7'(r_base + w_rsp.quo[6:0]);
                    r_st <= S_BLEND;
                end
                S_BLEND: begin
                    if (r_weight >= 8'd100) begin
                        r_lvl <= r_vp; r_st <= S_FIN;
                    end else if (r_weight == 8'd0) begin
                        r_lvl <= w_lp; r_st <= S_FIN;
                    end else begin
                        r_bnum <= w_bnum;
                        r_st <= S_BDIV;
                    end
                end
                S_BDIV: begin
                    r_lvl <= w_bq[25:19];
                    r_st <= S_FIN;
                end
                S_FIN: begin
                    if (r_smooth) begin
                        if (!r_seeded) begin
                            r_seeded <= 1'b1; r_slvl <= w_tgt; r_lvl <= w_tgt;
                        end else if (r_slvl != w_tgt) begin
                            if ((w_nx < $signed({2'b00, w_tgt})) == !w_sd[8]) begin
                                r_slvl <= w_nx[6:0]; r_lvl <= w_nx[6:0];
                            end else begin
                                r_slvl <= w_tgt; r_lvl <= w_tgt;
                            end
                        end else r_lvl <= r_slvl;
                    end else begin
                        r_slvl <= w_tgt; r_seeded <= 1'b0; r_lvl <= w_tgt;
                    end
                    r_st <= S_OUT;
                end
                S_DEMO: begin
                    if (r_simlvl == 8'd100) begin
                        if (r_demo > 10'd700) begin
                            r_demo <= w_dm5;
                            r_lvl <= w_dq[17:11];
                        end else begin
                            r_lvl <= 7'd70;
                        end
                    end
                    r_chg <= (r_b != 8'd0) && r_chg;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_odata <= {(r_chg ? (FLAG_CHG | FLAG_AC) : FLAG_DIS),
                                13'(r_lvl * 6'd60), r_lvl};
                    r_ouser <= r_changed;
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `BLE_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_st != S_IDLE, !s_axis_tready, "ready while busy")
    `BLE_ASSERT_NXT(a_out_after_seq, i_clk, i_rst_n, r_st == S_OUT, m_axis_tvalid, "no result after output step")
    `BLE_ASSERT_IMP(a_pct_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[6:0] <= 7'd100 && m_axis_tdata[6:0] >= 7'd5, "percent out of range")
endmodule
